FILE: hdl/rxup_pkg.sv
// Package: shared types and constants of the receive-buffer record unpacker.
`timescale 1ns / 1ps

package rxup_pkg;

   // Number of check bytes that trail the frame body
   localparam int CHECK_BYTES = 2;
   localparam logic [7:0] CHECK_BYTES_B = 8'(CHECK_BYTES);

   // Register reset value and register word indexes
   localparam logic [6:0] MAX_BODY_RESET = 7'd125;
   localparam logic       REG_MAX_BODY   = 1'b0;

   // Record parsing phase
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BODY,
      PH_CHECK,
      PH_LQI,
      PH_RSSI
   } rxup_phase_type;

   // Result kind codes
   typedef enum logic [1:0] {
      KIND_BODY = 2'd0,
      KIND_LQI  = 2'd1,
      KIND_RSSI = 2'd2,
      KIND_ERR  = 2'd3
   } rxup_kind_type;

   // One result transaction
   typedef struct packed {
      rxup_kind_type result_kind;
      logic [7:0]    data_byte;
      logic [6:0]    byte_index;
      logic [7:0]    body_length;
      logic          last_of_record;
   } rxup_result_type;

endpackage

FILE: hdl/rxup_out_skid.sv
// Output register with a skid stage for the result channel.
`timescale 1ns / 1ps

module rxup_out_skid (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  rxup_pkg::rxup_result_type push_data,
   output logic                      push_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rxup_pkg::rxup_result_type rsp_data
);

   logic                      out_valid_ff, out_valid_in;
   rxup_pkg::rxup_result_type out_data_ff, out_data_in;
   logic                      skid_valid_ff, skid_valid_in;
   rxup_pkg::rxup_result_type skid_data_ff, skid_data_in;
   logic                      drain;
   logic                      push;

   assign drain      = out_valid_ff && !rsp_stall;
   assign push       = push_valid && !skid_valid_ff;
   assign push_stall = skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   // Steer a new transaction into the output register or park it in the skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (drain) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff) begin
         if (drain) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || drain) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

FILE: hdl/radio_rx_fifo_record_unpacker_unit.sv
// Top level: radio receive-buffer record unpacker with its register port.
`timescale 1ns / 1ps
//
// Usage:
//   Feed receive-buffer bytes in address order on the req_ channel; flag the
//   length byte of each record with req_start_of_record. The rsp_ channel
//   returns one transaction per body byte (with its index), one for the
//   link-quality byte and one for the signal-strength byte, which closes the
//   record. A bad stored length gives a single error transaction instead.
//   Check bytes, length bytes and bytes outside a record give nothing.
//   A transaction is taken when valid is high and stall is low.
// Timing:
//   A byte is held in the input register and parsed there (a compare and a
//   counter update); the result is registered in the output register before
//   it shows on rsp_. One byte per cycle is sustained while the skid entry is empty.
// Stall and reset:
//   An output register plus a skid entry keep bytes flowing while the
//   receiver stalls; req_stall rises only once the skid entry is full.
//   Reset returns the parser to idle and max_body_length to 125.
//   Write max_body_length over the register port only while idle.

module radio_rx_fifo_record_unpacker_unit (
   input  logic        clock,
   input  logic        reset,
   // input byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_fifo_byte,
   input  logic        req_start_of_record,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [6:0]  rsp_byte_index,
   output logic [7:0]  rsp_body_length,
   output logic        rsp_last_of_record,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                      max_body_sel, max_body_wr;
   logic [6:0]                max_len_ff;
   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      in_start_ff;
   logic                      accept;
   logic                      fire;
   logic                      sk_stall;
   rxup_pkg::rxup_phase_type  phase_ff, phase_in;
   logic [7:0]                rem_ff, rem_in;
   logic [6:0]                idx_ff, idx_in;
   logic [7:0]                blen_ff, blen_in;
   logic [7:0]                blen_calc;
   logic                      len_short;
   logic                      len_long;
   logic                      res_has;
   rxup_pkg::rxup_result_type res;
   rxup_pkg::rxup_result_type rsp_data;

   // Register port: single word, always ready
   assign pready       = 1'b1;
   assign max_body_wr  = psel && penable && pwrite && (paddr[2] == rxup_pkg::REG_MAX_BODY);
   assign max_body_sel = (paddr[2] == rxup_pkg::REG_MAX_BODY);
   assign prdata       = max_body_sel ? {25'd0, max_len_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= rxup_pkg::MAX_BODY_RESET;
      end else if (max_body_wr) begin
         max_len_ff <= pwdata[6:0];
      end
   end

   // Input register: hold one byte until the parser can retire it
   assign fire      = in_valid_ff && !sk_stall;
   assign req_stall = in_valid_ff && sk_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_byte_ff  <= req_fifo_byte;
         in_start_ff <= req_start_of_record;
      end
   end

   // Length checks on a start byte
   assign blen_calc = in_byte_ff - rxup_pkg::CHECK_BYTES_B;
   assign len_short = in_byte_ff < rxup_pkg::CHECK_BYTES_B;
   assign len_long  = blen_calc > {1'b0, max_len_ff};

   // Next parser state
   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      blen_in  = blen_ff;
      if (fire) begin
         if (in_start_ff) begin
            idx_in = '0;
            if (len_short) begin
               blen_in  = '0;
               rem_in   = '0;
               phase_in = rxup_pkg::PH_IDLE;
            end else begin
               blen_in = blen_calc;
               if (len_long) begin
                  rem_in   = '0;
                  phase_in = rxup_pkg::PH_IDLE;
               end else if (blen_calc == 8'd0) begin
                  if (rxup_pkg::CHECK_BYTES == 0) begin
                     phase_in = rxup_pkg::PH_LQI;
                     rem_in   = '0;
                  end else begin
                     phase_in = rxup_pkg::PH_CHECK;
                     rem_in   = rxup_pkg::CHECK_BYTES_B;
                  end
               end else begin
                  phase_in = rxup_pkg::PH_BODY;
                  rem_in   = blen_calc;
               end
            end
         end else begin
            unique case (phase_ff)
               rxup_pkg::PH_BODY: begin
                  idx_in = idx_ff + 7'd1;
                  rem_in = rem_ff - 8'd1;
                  if (rem_ff == 8'd1) begin
                     if (rxup_pkg::CHECK_BYTES == 0) begin
                        phase_in = rxup_pkg::PH_LQI;
                        rem_in   = '0;
                     end else begin
                        phase_in = rxup_pkg::PH_CHECK;
                        rem_in   = rxup_pkg::CHECK_BYTES_B;
                     end
                  end
               end
               rxup_pkg::PH_CHECK: begin
                  rem_in = rem_ff - 8'd1;
                  if (rem_ff == 8'd1) begin
                     phase_in = rxup_pkg::PH_LQI;
                  end
               end
               rxup_pkg::PH_LQI: begin
                  phase_in = rxup_pkg::PH_RSSI;
               end
               rxup_pkg::PH_RSSI: begin
                  phase_in = rxup_pkg::PH_IDLE;
                  rem_in   = '0;
               end
               default: begin
                  phase_in = rxup_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   // Result for the byte being retired
   always_comb begin
      res_has            = 1'b0;
      res.result_kind    = rxup_pkg::KIND_ERR;
      res.data_byte      = in_byte_ff;
      res.byte_index     = '0;
      res.body_length    = blen_ff;
      res.last_of_record = 1'b0;
      if (in_start_ff) begin
         res.data_byte      = '0;
         res.last_of_record = 1'b1;
         res.body_length    = len_short ? 8'd0 : blen_calc;
         res_has            = len_short || len_long;
      end else begin
         unique case (phase_ff)
            rxup_pkg::PH_BODY: begin
               res_has         = 1'b1;
               res.result_kind = rxup_pkg::KIND_BODY;
               res.byte_index  = idx_ff;
            end
            rxup_pkg::PH_LQI: begin
               res_has         = 1'b1;
               res.result_kind = rxup_pkg::KIND_LQI;
            end
            rxup_pkg::PH_RSSI: begin
               res_has            = 1'b1;
               res.result_kind    = rxup_pkg::KIND_RSSI;
               res.last_of_record = 1'b1;
            end
            default: begin
               res_has = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rxup_pkg::PH_IDLE;
         rem_ff   <= '0;
         idx_ff   <= '0;
         blen_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         idx_ff   <= idx_in;
         blen_ff  <= blen_in;
      end
   end

   // Result buffering toward the receiver
   rxup_out_skid u_out_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fire && res_has),
      .push_data  (res),
      .push_stall (sk_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_result_kind    = rsp_data.result_kind;
   assign rsp_data_byte      = rsp_data.data_byte;
   assign rsp_byte_index     = rsp_data.byte_index;
   assign rsp_body_length    = rsp_data.body_length;
   assign rsp_last_of_record = rsp_data.last_of_record;

`ifndef NO_ASSERTIONS
   // Body phase always has bytes left, and index plus remaining equals length
   a_body_count : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rxup_pkg::PH_BODY) |->
         (rem_ff != 8'd0) && (({2'b0, idx_ff} + {1'b0, rem_ff}) == {1'b0, blen_ff}))
      else $error("body counters out of step");

   // Check phase counts down from the check-byte count
   a_check_count : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rxup_pkg::PH_CHECK) |->
         (rem_ff != 8'd0) && (rem_ff <= rxup_pkg::CHECK_BYTES_B))
      else $error("check-byte counter out of range");

   // Input stalls only while a byte is held that cannot retire
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && sk_stall && rsp_valid))
      else $error("input stalled without a blocked byte");

   // A retired byte leaves the input register empty unless a new one came in
   a_retire : assert property (@(posedge clock) disable iff (reset)
      (fire && !accept) |=> !in_valid_ff)
      else $error("retired byte still held");
`endif

endmodule

FILE: verif/tb.sv
// Testbench: random and directed traffic with a scoreboard for the record unpacker.
`timescale 1ns / 1ps

module tb;

   localparam int          CLOCK_PERIOD   = 10;
   localparam int          RESET_CYCLES   = 11;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          LONG_HOLD      = 300;
   localparam longint      TIMEOUT_NS     = 4_000_000;
   localparam logic [2:0]  CSR_MAX_BODY_ADDR = 3'(4 * int'(rxup_pkg::REG_MAX_BODY));

   // Scoreboard: tracks record parsing and holds the results still owed
   class rx_record_scoreboard;
      rxup_pkg::rxup_result_type pending_q[$];
      int unsigned               error_count;
      int unsigned               taken_count;
      logic [6:0]                max_body;
      rxup_pkg::rxup_phase_type  phase;
      logic [7:0]                remaining;
      logic [6:0]                body_index;
      logic [7:0]                body_len;

      function new();
         error_count = 0;
         taken_count = 0;
         max_body    = rxup_pkg::MAX_BODY_RESET;
         phase       = rxup_pkg::PH_IDLE;
         remaining   = '0;
         body_index  = '0;
         body_len    = '0;
      endfunction

      task report_mismatch(input string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         error_count++;
      endtask

      function void set_limit(input logic [6:0] value);
         max_body = value;
      endfunction

      function void open_check();
         if (rxup_pkg::CHECK_BYTES == 0) begin
            phase     = rxup_pkg::PH_LQI;
            remaining = '0;
         end else begin
            phase     = rxup_pkg::PH_CHECK;
            remaining = rxup_pkg::CHECK_BYTES_B;
         end
      endfunction

      function void owe(input rxup_pkg::rxup_kind_type kind, input logic [7:0] data,
                        input logic [6:0] idx, input logic last);
         rxup_pkg::rxup_result_type r;
         r.result_kind    = kind;
         r.data_byte      = data;
         r.byte_index     = idx;
         r.body_length    = body_len;
         r.last_of_record = last;
         pending_q.push_back(r);
      endfunction

      // Advance the parser by one accepted byte and queue what it owes
      function void note_byte(input logic [7:0] b, input logic start);
         if (start || phase != rxup_pkg::PH_IDLE)
            taken_count++;
         if (start) begin
            body_index = '0;
            if (b < rxup_pkg::CHECK_BYTES_B) begin
               body_len  = '0;
               remaining = '0;
               phase     = rxup_pkg::PH_IDLE;
               owe(rxup_pkg::KIND_ERR, 8'h00, 7'd0, 1'b1);
            end else begin
               body_len = b - rxup_pkg::CHECK_BYTES_B;
               if (body_len > {1'b0, max_body}) begin
                  remaining = '0;
                  phase     = rxup_pkg::PH_IDLE;
                  owe(rxup_pkg::KIND_ERR, 8'h00, 7'd0, 1'b1);
               end else if (body_len == 8'd0) begin
                  open_check();
               end else begin
                  phase     = rxup_pkg::PH_BODY;
                  remaining = body_len;
               end
            end
         end else begin
            case (phase)
               rxup_pkg::PH_BODY: begin
                  owe(rxup_pkg::KIND_BODY, b, body_index, 1'b0);
                  body_index = body_index + 7'd1;
                  remaining  = remaining - 8'd1;
                  if (remaining == 8'd0)
                     open_check();
               end
               rxup_pkg::PH_CHECK: begin
                  remaining = remaining - 8'd1;
                  if (remaining == 8'd0)
                     phase = rxup_pkg::PH_LQI;
               end
               rxup_pkg::PH_LQI: begin
                  owe(rxup_pkg::KIND_LQI, b, 7'd0, 1'b0);
                  phase = rxup_pkg::PH_RSSI;
               end
               rxup_pkg::PH_RSSI: begin
                  owe(rxup_pkg::KIND_RSSI, b, 7'd0, 1'b1);
                  phase     = rxup_pkg::PH_IDLE;
                  remaining = '0;
               end
               default: phase = rxup_pkg::PH_IDLE;
            endcase
         end
      endfunction

      // Compare one result transaction with the oldest one owed
      task check_result(input rxup_pkg::rxup_result_type got);
         rxup_pkg::rxup_result_type want;
         if (pending_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d data %02h",
                                      got.result_kind, got.data_byte));
         end else begin
            want = pending_q.pop_front();
            if (got.result_kind !== want.result_kind)
               report_mismatch($sformatf("result_kind %0d, want %0d",
                                         got.result_kind, want.result_kind));
            if (got.data_byte !== want.data_byte)
               report_mismatch($sformatf("data_byte %02h, want %02h",
                                         got.data_byte, want.data_byte));
            if (got.byte_index !== want.byte_index)
               report_mismatch($sformatf("byte_index %0d, want %0d",
                                         got.byte_index, want.byte_index));
            if (got.body_length !== want.body_length)
               report_mismatch($sformatf("body_length %0d, want %0d",
                                         got.body_length, want.body_length));
            if (got.last_of_record !== want.last_of_record)
               report_mismatch($sformatf("last_of_record %0b, want %0b",
                                         got.last_of_record, want.last_of_record));
         end
      endtask

      task close_out();
         if (pending_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_q.size()));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_fifo_byte = 8'h00;
   logic        req_start_of_record = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_data_byte;
   logic [6:0]  rsp_byte_index;
   logic [7:0]  rsp_body_length;
   logic        rsp_last_of_record;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   rx_record_scoreboard       sb = new();
   rxup_pkg::rxup_result_type seen_result;
   int unsigned               gap_odds   = 4;
   int unsigned               stall_odds = 4;
   logic                      hold_request = 1'b0;

   radio_rx_fifo_record_unpacker_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_fifo_byte      (req_fifo_byte),
      .req_start_of_record(req_start_of_record),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_body_length    (rsp_body_length),
      .rsp_last_of_record (rsp_last_of_record),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Check every result transaction taken at this edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result.result_kind    = rxup_pkg::rxup_kind_type'(rsp_result_kind);
         seen_result.data_byte      = rsp_data_byte;
         seen_result.byte_index     = rsp_byte_index;
         seen_result.body_length    = rsp_body_length;
         seen_result.last_of_record = rsp_last_of_record;
         sb.check_result(seen_result);
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      int unsigned n;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            n = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one byte, optionally after an idle burst, and hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic start);
      int unsigned n;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         n = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_fifo_byte       <= b;
      req_start_of_record <= start;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, start);
   endtask

   // Send the first count bytes of a record with the given body length
   task automatic send_record(input int unsigned blen, input int unsigned count);
      for (int unsigned k = 0; k < count; k++) begin
         if (k == 0)
            send_byte(8'(blen + rxup_pkg::CHECK_BYTES), 1'b1);
         else
            send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // Mostly short bodies, now and then the largest one allowed
   function automatic int unsigned pick_body();
      int unsigned r;
      int unsigned cap;
      r   = $urandom_range(0, 15);
      cap = (sb.max_body < 10) ? sb.max_body : 10;
      if (r == 0)
         return sb.max_body;
      else if (r == 1)
         return $urandom_range(0, sb.max_body);
      else
         return $urandom_range(0, cap);
   endfunction

   // One random stretch of traffic: a record, a bad length, a cut record or noise
   task automatic random_traffic();
      int unsigned pick;
      int unsigned blen;
      int unsigned full;
      pick = $urandom_range(0, 99);
      blen = pick_body();
      full = blen + rxup_pkg::CHECK_BYTES + 3;
      if (pick < 74) begin
         send_record(blen, full);
      end else if (pick < 79) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 85 && rxup_pkg::CHECK_BYTES > 0) begin
         send_byte(8'($urandom_range(0, rxup_pkg::CHECK_BYTES - 1)), 1'b1);
      end else if (pick < 92) begin
         send_byte(8'($urandom_range(sb.max_body + 1 + rxup_pkg::CHECK_BYTES, 255)), 1'b1);
      end else begin
         send_record(blen, $urandom_range(1, full - 1));
      end
   endtask

   // Stop offering and let every owed result come out, then settle
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [6:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_MAX_BODY_ADDR;
      pwdata  <= {25'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_limit(value);
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [6:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_MAX_BODY_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[6:0] !== value)
         sb.report_mismatch($sformatf("max_body_length reads %0d, want %0d",
                                      prdata[6:0], value));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write a new limit while idle, then run random traffic under it
   task automatic run_phase(input logic [6:0] limit, input int unsigned items,
                            input int unsigned odds);
      int unsigned target;
      wait_drain();
      csr_write(limit);
      csr_check(limit);
      gap_odds   = odds;
      stall_odds = odds;
      target     = sb.taken_count + items;
      while (sb.taken_count < target) random_traffic();
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(rxup_pkg::MAX_BODY_RESET);

      // Directed: idle noise, short lengths, empty body, oversize, byte extremes
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h01, 1'b1);
      send_byte(8'h02, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'h05, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b0);
      // Start flag inside a record drops it and opens a new one
      send_byte(8'h06, 1'b1);
      send_byte(8'h11, 1'b0);
      send_record(1, 1 + rxup_pkg::CHECK_BYTES + 3);

      // Random phases across limits, extremes included
      run_phase(rxup_pkg::MAX_BODY_RESET, 450, 4);
      wait_drain();
      run_phase(7'd0, 150, 3);
      run_phase(7'd127, 250, 5);

      // Long receiver hold-off while a long record keeps coming
      gap_odds     = 0;
      hold_request = 1'b1;
      send_record(100, 100 + rxup_pkg::CHECK_BYTES + 3);
      wait_drain();

      run_phase(7'($urandom_range(1, 126)), 300, 6);
      run_phase(7'($urandom_range(1, 126)), 250, 2);
      run_phase(rxup_pkg::MAX_BODY_RESET, 200, 0);

      wait_drain();
      sb.close_out();
      if (sb.error_count == 0)
         $display("PASS radio_rx_fifo_record_unpacker_unit");
      else
         $display("FAIL radio_rx_fifo_record_unpacker_unit");
      $finish;
   end

   // Guard against a hung handshake
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("FAIL radio_rx_fifo_record_unpacker_unit");
      $finish;
   end

endmodule
